// ----- hdl/cpa_pkg.sv -----
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

   localparam int MAX_PAGES = 1024;
   localparam int PAGE_W    = $clog2(MAX_PAGES);
   localparam int CNT_W     = PAGE_W + 1;
   localparam int OWNER_W   = 15;
   localparam int VADDR_W   = 32;

   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_PIN   = 3'd2;
   localparam logic [2:0] OP_UNPIN = 3'd3;
   localparam logic [2:0] OP_DIRTY = 3'd4;
   localparam logic [2:0] OP_CLEAN = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_PINNED  = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   localparam int FL_INUSE = 0;
   localparam int FL_CONT  = 1;
   localparam int FL_EVICT = 2;
   localparam int FL_DIRTY = 3;

   typedef struct packed {
      logic [2:0]         op;
      logic [PAGE_W-1:0]  page_index;
      logic [CNT_W-1:0]   run_length;
      logic [OWNER_W-1:0] owner_id;
      logic [VADDR_W-1:0] virt_addr;
      logic               is_kernel;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] first_page;
      logic [CNT_W-1:0]  count;
   } rsp_type;

   typedef struct packed {
      logic               used;
      logic               pinned;
      logic [3:0]         flags;
      logic [OWNER_W-1:0] owner;
      logic [VADDR_W-1:0] vaddr;
   } entry_type;

endpackage

// ----- hdl/cpa_if.sv -----
// ----------------------------------------------------------------------------
// cpa_if
// Valid/ready channels of the contiguous page allocator.
// ----------------------------------------------------------------------------
interface cpa_req_if;
   import cpa_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cpa_rsp_if;
   import cpa_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cpa_csr_if;
   import cpa_pkg::*;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/cpa_ram.sv -----
// ----------------------------------------------------------------------------
// cpa_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module cpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ----- hdl/contiguous_page_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous runs over a physical page frame table.
//
// req carries one operation per transaction (allocate, free, pin, unpin,
// mark dirty, mark clean); rsp returns one result per transaction with
// status, first page and count. csr writes the page count at any time the
// block is idle and is always ready.
// The frame table lives in one memory with one write and one registered
// read port. Allocate scans it one frame per cycle from frame 0 and then
// writes the run one frame per cycle. Free walks the continuation marks
// one frame per cycle. Pin, unpin, dirty and clean read, modify and write
// one frame. Range errors and zero-length allocations answer from idle.
// After reset the memory is cleared frame by frame, during which req is
// not ready. A finished result waits in the rsp register while the next
// transaction is taken; if rsp is still stalled when that one finishes,
// it is held and req stays low until rsp drains.
// ----------------------------------------------------------------------------
module contiguous_page_allocator (
   input logic        clock,
   input logic        reset,
   cpa_req_if.sink    req,
   cpa_rsp_if.source  rsp,
   cpa_csr_if.sink    csr
);
   import cpa_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_FILL   = 3'd3;
   localparam logic [2:0] S_FREE   = 3'd4;
   localparam logic [2:0] S_MODIFY = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   localparam int EW = $bits(entry_type);

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   page_count_ff, page_count_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               chk_valid_ff, chk_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]   run_ff, run_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PAGE_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]   pc_ff, pc_in;
   req_type            cmd_ff, cmd_in;
   rsp_type            pend_ff, pend_in;
   rsp_type            out_ff, out_in;

   logic               we;
   logic [PAGE_W-1:0]  waddr, raddr;
   entry_type          wdata, rdata, mod;
   logic [EW-1:0]      rdata_raw;
   logic [CNT_W-1:0]   live;
   logic               fin, rsp_free;
   rsp_type            fin_rsp;

   cpa_ram #(.WIDTH(EW), .DEPTH(MAX_PAGES)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata_raw)
   );

   assign rdata     = entry_type'(rdata_raw);
   assign live      = (page_count_ff > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count_ff;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      state_in      = state_ff;
      page_count_in = page_count_ff;
      scan_in       = scan_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      run_in        = run_ff;
      cnt_in        = cnt_ff;
      start_in      = start_ff;
      pc_in         = pc_ff;
      cmd_in        = cmd_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      we            = 1'b0;
      waddr         = '0;
      wdata         = '0;
      raddr         = '0;
      mod           = rdata;
      fin           = 1'b0;
      fin_rsp       = '0;

      if (csr.valid) begin
         page_count_in = csr.payload;
      end

      case (state_ff)
         S_CLEAR: begin
            we      = 1'b1;
            waddr   = scan_ff[PAGE_W-1:0];
            scan_in = scan_ff + CNT_W'(1);
            if (scan_ff[PAGE_W-1:0] == PAGE_W'(MAX_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               cmd_in          = req.payload;
               pc_in           = live;
               fin_rsp.first_page = req.payload.page_index;
               case (req.payload.op)
                  OP_ALLOC: begin
                     if (req.payload.run_length == '0) begin
                        fin            = 1'b1;
                        fin_rsp.status = ST_NOSPACE;
                     end else begin
                        scan_in  = '0;
                        run_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE, OP_PIN, OP_UNPIN, OP_DIRTY, OP_CLEAN: begin
                     if ({1'b0, req.payload.page_index} >= live) begin
                        fin            = 1'b1;
                        fin_rsp.status = ST_RANGE;
                     end else if (req.payload.op == OP_FREE) begin
                        we       = 1'b1;
                        waddr    = req.payload.page_index;
                        cnt_in   = CNT_W'(1);
                        scan_in  = {1'b0, req.payload.page_index} + CNT_W'(1);
                        state_in = S_FREE;
                     end else begin
                        raddr    = req.payload.page_index;
                        state_in = S_MODIFY;
                     end
                  end
                  default: begin
                     fin            = 1'b1;
                     fin_rsp.status = ST_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            raddr        = scan_ff[PAGE_W-1:0];
            chk_valid_in = (scan_ff < pc_ff);
            chk_idx_in   = scan_ff[PAGE_W-1:0];
            if (scan_ff < pc_ff) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (chk_valid_ff) begin
               if (rdata.used) begin
                  run_in = '0;
               end else begin
                  run_in = run_ff + CNT_W'(1);
                  if (run_ff + CNT_W'(1) == cmd_ff.run_length) begin
                     start_in     = chk_idx_ff - cmd_ff.run_length[PAGE_W-1:0] + PAGE_W'(1);
                     cnt_in       = '0;
                     chk_valid_in = 1'b0;
                     state_in     = S_FILL;
                  end
               end
            end else if (scan_ff >= pc_ff) begin
               fin                = 1'b1;
               fin_rsp.status     = ST_NOSPACE;
               fin_rsp.first_page = cmd_ff.page_index;
            end
         end
         S_FILL: begin
            we                    = 1'b1;
            waddr                 = start_ff + cnt_ff[PAGE_W-1:0];
            wdata.used            = 1'b1;
            wdata.pinned          = 1'b1;
            wdata.flags[FL_INUSE] = 1'b1;
            wdata.flags[FL_CONT]  = (cnt_ff != '0);
            wdata.flags[FL_EVICT] = !cmd_ff.is_kernel;
            wdata.owner           = cmd_ff.owner_id;
            wdata.vaddr           = cmd_ff.is_kernel ? '0 : cmd_ff.virt_addr;
            cnt_in                = cnt_ff + CNT_W'(1);
            if (cnt_ff + CNT_W'(1) == cmd_ff.run_length) begin
               fin                = 1'b1;
               fin_rsp.status     = ST_OK;
               fin_rsp.first_page = start_ff;
               fin_rsp.count      = cmd_ff.run_length;
            end
         end
         S_FREE: begin
            raddr        = scan_ff[PAGE_W-1:0];
            chk_valid_in = (scan_ff < pc_ff);
            chk_idx_in   = scan_ff[PAGE_W-1:0];
            if (scan_ff < pc_ff) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            fin_rsp.status     = ST_OK;
            fin_rsp.first_page = cmd_ff.page_index;
            fin_rsp.count      = cnt_ff;
            if (chk_valid_ff) begin
               if (rdata.flags[FL_CONT]) begin
                  we     = 1'b1;
                  waddr  = chk_idx_ff;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  fin = 1'b1;
               end
            end else if (scan_ff >= pc_ff) begin
               fin = 1'b1;
            end
         end
         S_MODIFY: begin
            fin                = 1'b1;
            fin_rsp.status     = ST_OK;
            fin_rsp.first_page = cmd_ff.page_index;
            waddr              = cmd_ff.page_index;
            we                 = 1'b1;
            case (cmd_ff.op)
               OP_PIN: begin
                  if (rdata.pinned) begin
                     we             = 1'b0;
                     fin_rsp.status = ST_PINNED;
                  end else begin
                     mod.pinned = 1'b1;
                  end
               end
               OP_UNPIN: mod.pinned = 1'b0;
               OP_DIRTY: mod.flags[FL_DIRTY] = 1'b1;
               OP_CLEAN: mod.flags[FL_DIRTY] = 1'b0;
               default:  we = 1'b0;
            endcase
            wdata = mod;
         end
         S_DONE: begin
            if (rsp_free) begin
               out_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (fin) begin
         if (rsp_free) begin
            out_in       = fin_rsp;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            pend_in  = fin_rsp;
            state_in = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         page_count_ff <= CNT_W'(MAX_PAGES);
         scan_ff       <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         page_count_ff <= page_count_in;
         scan_ff       <= scan_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      run_ff     <= run_in;
      cnt_ff     <= cnt_in;
      start_ff   <= start_in;
      pc_ff      <= pc_in;
      cmd_ff     <= cmd_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end
endmodule

// ----- bench/cpa_checker.sv -----
// ----------------------------------------------------------------------------
// cpa_checker
// Watches the request, response and page count channels of the contiguous
// page allocator, keeps its own copy of the frame table, predicts every
// response and compares every field with what the block returns.
// ----------------------------------------------------------------------------
module cpa_checker
   import cpa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  req_type  req_payload,
   input  logic     rsp_valid,
   input  logic     rsp_ready,
   input  rsp_type  rsp_payload,
   input  logic     csr_valid,
   input  logic     csr_ready,
   input  logic [CNT_W-1:0] csr_payload,
   output int       fail_count,
   output int       pending,
   output int       alloc_hits,
   output int       free_hits
);

   logic               used_map   [MAX_PAGES];
   logic               pinned_map [MAX_PAGES];
   logic [3:0]         flag_map   [MAX_PAGES];
   logic [OWNER_W-1:0] owner_map  [MAX_PAGES];
   logic [VADDR_W-1:0] vaddr_map  [MAX_PAGES];
   logic [CNT_W-1:0]   page_limit;
   rsp_type            expected_rsp [$];

   function automatic int live_pages();
      return (page_limit > MAX_PAGES) ? MAX_PAGES : int'(page_limit);
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type o;
      int pc, run, start, n;
      bit found;
      pc = live_pages();
      o.status = ST_OK;
      o.first_page = r.page_index;
      o.count = '0;
      if (r.op == OP_ALLOC) begin
         run = 0;
         found = 0;
         start = 0;
         if (r.run_length != 0) begin
            for (int i = 0; i < pc && !found; i++) begin
               if (used_map[i]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == r.run_length) begin
                     start = i + 1 - run;
                     found = 1;
                  end
               end
            end
         end
         if (!found) begin
            o.status = ST_NOSPACE;
         end else begin
            for (int i = 0; i < r.run_length; i++) begin
               used_map[start+i] = 1;
               pinned_map[start+i] = 1;
               flag_map[start+i] = 4'b0001;
               flag_map[start+i][FL_CONT] = (i > 0);
               flag_map[start+i][FL_EVICT] = !r.is_kernel;
               owner_map[start+i] = r.owner_id;
               vaddr_map[start+i] = r.is_kernel ? '0 : r.virt_addr;
            end
            o.first_page = start[PAGE_W-1:0];
            o.count = r.run_length;
         end
      end else if (r.op <= OP_CLEAN) begin
         if (r.page_index >= pc) begin
            o.status = ST_RANGE;
         end else if (r.op == OP_FREE) begin
            n = 1;
            while (r.page_index + n < pc && flag_map[r.page_index+n][FL_CONT]) n++;
            for (int i = 0; i < n; i++) begin
               used_map[r.page_index+i] = 0;
               pinned_map[r.page_index+i] = 0;
               flag_map[r.page_index+i] = '0;
               owner_map[r.page_index+i] = '0;
               vaddr_map[r.page_index+i] = '0;
            end
            o.count = n[CNT_W-1:0];
         end else if (r.op == OP_PIN) begin
            if (pinned_map[r.page_index]) o.status = ST_PINNED;
            else pinned_map[r.page_index] = 1;
         end else if (r.op == OP_UNPIN) begin
            pinned_map[r.page_index] = 0;
         end else if (r.op == OP_DIRTY) begin
            flag_map[r.page_index][FL_DIRTY] = 1;
         end else begin
            flag_map[r.page_index][FL_DIRTY] = 0;
         end
      end
      return o;
   endfunction

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_PAGES; i++) begin
            used_map[i] = 0;
            pinned_map[i] = 0;
            flag_map[i] = '0;
            owner_map[i] = '0;
            vaddr_map[i] = '0;
         end
         page_limit = CNT_W'(1024);
         expected_rsp.delete();
         fail_count = 0;
         alloc_hits = 0;
         free_hits = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response status=%0d first=%0d count=%0d",
                           rsp_payload.status, rsp_payload.first_page, rsp_payload.count);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch exp status=%0d first=%0d count=%0d got %0d %0d %0d",
                              want.status, want.first_page, want.count, rsp_payload.status,
                              rsp_payload.first_page, rsp_payload.count);
               end
            end
         end
         if (csr_valid && csr_ready) page_limit = csr_payload;
         if (req_valid && req_ready) begin
            want = apply_request(req_payload);
            if (req_payload.op == OP_ALLOC && want.status == ST_OK) alloc_hits++;
            if (req_payload.op == OP_FREE && want.status == ST_OK) free_hits++;
            expected_rsp.push_back(want);
         end
      end
   end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the contiguous page allocator: directed corner cases, then
// random phases over several page counts with mostly allocate/free traffic
// aimed at live runs, random gaps on both channels and a long response stall.
// ----------------------------------------------------------------------------
module tb_top;
   import cpa_pkg::*;

   localparam int WATCH_LIMIT = 200000;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending, alloc_hits, free_hits;
   int   req_total = 0;
   int   idle_cycles = 0;
   bit   long_stall = 0;
   int   run_heads [$];

   cpa_req_if req_ch ();
   cpa_rsp_if rsp_ch ();
   cpa_csr_if csr_ch ();

   contiguous_page_allocator dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   cpa_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_payload (req_ch.payload),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_ch.payload),
      .csr_valid   (csr_ch.valid),
      .csr_ready   (csr_ch.ready),
      .csr_payload (csr_ch.payload),
      .fail_count  (fail_count),
      .pending     (pending),
      .alloc_hits  (alloc_hits),
      .free_hits   (free_hits)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0;
      csr_ch.payload = '0;
   end

   // cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("timeout");
         $display("status: fail");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (long_stall) begin
            rsp_ch.ready <= 0;
            repeat (3000) @(negedge clock);
            long_stall = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_ch.ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_req(req_type r, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_ch.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.payload = r;
      req_ch.valid = 1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      req_total++;
      @(negedge clock);
      req_ch.valid = 0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (1100) @(negedge clock);
   endtask

   task automatic write_page_count(int value);
      csr_ch.payload <= value[CNT_W-1:0];
      csr_ch.valid <= 1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 0;
      @(negedge clock);
   endtask

   function automatic req_type make_req(logic [2:0] op, int page, int len, bit kern);
      req_type r;
      r.op = op;
      r.page_index = page[PAGE_W-1:0];
      r.run_length = len[CNT_W-1:0];
      r.owner_id = OWNER_W'($urandom());
      r.virt_addr = $urandom();
      r.is_kernel = kern;
      return r;
   endfunction

   function automatic req_type random_req(int limit);
      req_type r;
      int pick, len;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
                                            : $urandom_range(1, 24);
         r = make_req(OP_ALLOC, $urandom_range(0, 1023), len, 1'($urandom_range(0, 1)));
      end else if (pick < 70 && run_heads.size() > 0) begin
         r = make_req(OP_FREE, run_heads[$urandom_range(0, run_heads.size() - 1)],
                      $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
         r = make_req(3'($urandom_range(1, 5)),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, limit),
                      $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
      end else begin
         r = make_req(3'($urandom_range(6, 7)), $urandom_range(0, 1023),
                      $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
      end
      return r;
   endfunction

   // first page of the newest response with a nonzero count (allocation or free), taken from the response bus
   int last_alloc_first = 0;
   always @(posedge clock)
      if (rsp_ch.valid && rsp_ch.ready && rsp_ch.payload.count != 0)
         last_alloc_first <= rsp_ch.payload.first_page;

   function automatic int checker_last_first();
      return last_alloc_first;
   endfunction

   task automatic random_phase(int page_count, int items);
      req_type r;
      int limit;
      limit = (page_count > 0) ? ((page_count > 1024 ? 1024 : page_count) - 1) : 0;
      run_heads.delete();
      for (int i = 0; i < items; i++) begin
         r = random_req(limit);
         send_req(r, ($urandom_range(0, 4) != 0));
         if (r.op == OP_ALLOC) begin
            while (pending != 0) @(negedge clock);
            run_heads.push_back(0);
         end
         if (run_heads.size() > 0 && r.op == OP_ALLOC)
            run_heads[run_heads.size() - 1] = checker_last_first();
      end
   endtask

   initial begin
      req_type r;
      repeat (2) @(negedge clock);
      reset = 0;
      @(negedge clock);
      write_page_count(1024);

      // directed corners
      send_req(make_req(OP_ALLOC, 0, 0, 0), 0);
      send_req(make_req(OP_ALLOC, 0, 1024, 0), 0);
      send_req(make_req(OP_FREE, 0, 0, 0), 0);
      send_req(make_req(OP_ALLOC, 1023, 3, 1), 0);
      r = make_req(OP_ALLOC, 0, 5, 0);
      r.owner_id = '1;
      r.virt_addr = '1;
      send_req(r, 0);
      send_req(make_req(OP_PIN, 0, 0, 0), 0);
      send_req(make_req(OP_UNPIN, 0, 0, 0), 0);
      send_req(make_req(OP_PIN, 0, 0, 0), 0);
      send_req(make_req(OP_DIRTY, 4, 0, 0), 0);
      send_req(make_req(OP_CLEAN, 4, 0, 0), 0);
      send_req(make_req(OP_FREE, 4, 0, 0), 0);
      send_req(make_req(OP_FREE, 1, 0, 0), 0);
      send_req(make_req(3'd6, 1023, 2047, 1), 0);
      send_req(make_req(3'd7, 512, 0, 0), 0);
      send_req(make_req(OP_ALLOC, 0, 1024, 0), 0);
      send_req(make_req(OP_FREE, 1023, 0, 0), 0);
      send_req(make_req(OP_FREE, 0, 0, 0), 0);
      send_req(make_req(OP_ALLOC, 0, 2047, 1), 0);
      send_req(make_req(OP_ALLOC, 0, 1020, 0), 0);
      send_req(make_req(OP_FREE, 1010, 0, 0), 0);
      drain();

      // short table: a range error and free hitting the last frame
      write_page_count(16);
      send_req(make_req(OP_PIN, 16, 0, 0), 0);
      send_req(make_req(OP_ALLOC, 0, 17, 0), 0);
      send_req(make_req(OP_ALLOC, 0, 16, 0), 0);
      send_req(make_req(OP_FREE, 15, 0, 0), 0);
      drain();

      write_page_count(0);
      send_req(make_req(OP_ALLOC, 0, 1, 0), 0);
      send_req(make_req(OP_DIRTY, 0, 0, 0), 0);
      drain();

      // response hold-off while requests keep coming
      write_page_count(1);
      long_stall = 1;
      for (int i = 0; i < 12; i++)
         send_req(make_req(3'($urandom_range(1, 5)), $urandom_range(0, 1), 0, 0), 0);
      drain();

      write_page_count(64);
      random_phase(64, 200);
      drain();
      write_page_count(2047);
      random_phase(2047, 120);
      drain();
      write_page_count(1);
      random_phase(1, 60);
      drain();
      write_page_count(200);
      random_phase(200, 180);
      drain();

      $display("covered %0d requests over page counts 0 to 2047", req_total);
      $display("%0d runs allocated, %0d runs freed", alloc_hits, free_hits);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
